// File: rtl/cas_pkg.sv
`default_nettype none
package cas_pkg;

   localparam int Slots        = 16;
   localparam int SlotBits     = 4;
   localparam int MaxChunks    = 256;
   localparam int WordsPerSlot = 4;
   localparam int WordBits     = 2;
   localparam int BitmapDepth  = Slots * WordsPerSlot;
   localparam int BitmapAddrW  = 6;

   localparam logic [2:0] OP_ADD   = 3'd0;
   localparam logic [2:0] OP_INIT  = 3'd1;
   localparam logic [2:0] OP_CHUNK = 3'd2;
   localparam logic [2:0] OP_STATE = 3'd3;
   localparam logic [2:0] OP_REMOVE = 3'd4;
   localparam logic [2:0] OP_QUERY = 3'd5;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_INVALID   = 3'd2;
   localparam logic [2:0] ST_DUPLICATE = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;
   localparam logic [2:0] ST_TOO_MANY  = 3'd5;

   localparam logic [2:0] RQ_ASSIGNED  = 3'd0;
   localparam logic [2:0] RQ_COMPLETED = 3'd6;
   localparam logic [2:0] RQ_FAILED    = 3'd7;

   typedef struct packed {
      logic [2:0]  operation;
      logic [15:0] seq;
      logic [31:0] imm_word;
      logic [15:0] chunk_total;
      logic [2:0]  target_state;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] seq_out;
      logic [2:0]  state_out;
      logic [8:0]  received;
      logic [8:0]  expected;
      logic        complete;
      logic [31:0] total_added;
      logic [31:0] completed_count;
      logic [31:0] failed_count;
      logic [4:0]  active_count;
   } rsp_type;

endpackage
`default_nettype wire

// File: rtl/chunk_arrival_scoreboard.sv
// An accepted request word passes the READ, EXEC and OUT states (init adds CLEAR,
// which clears its four bitmap words one per cycle) before its response word is
// registered; a new word is accepted only back in IDLE, as set by the slot-record memory
// read-modify-write and bitmap port. A stalled response holds the next word in its last stage.
// Reset: synchronous, clears valid bits, counters and next sequence number (to 1).
// Memories need no clearing pass; slot records are guarded by per-slot valid bits.
`default_nettype none
module chunk_arrival_scoreboard (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  cas_pkg::req_type       req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output cas_pkg::rsp_type       rsp_data
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_EXEC  = 3'd2;
   localparam logic [2:0] S_CLEAR = 3'd3;
   localparam logic [2:0] S_OUT   = 3'd4;

   // Slot record memory: seq, state, received, expected.
   typedef struct packed {
      logic [15:0] seq;
      logic [2:0]  state;
      logic [8:0]  received;
      logic [8:0]  expected;
   } rec_type;

   rec_type     rec_mem [cas_pkg::Slots];
   logic [63:0] bit_mem [cas_pkg::BitmapDepth];
   logic [15:0] tag_ff  [cas_pkg::Slots];

   logic [2:0]  fsm_ff, fsm_in;
   cas_pkg::req_type req_ff;
   logic [cas_pkg::Slots-1:0] valid_ff, valid_in;
   logic [15:0] next_seq_ff, next_seq_in;
   logic [31:0] added_ff, added_in, done_ff, done_in, fail_ff, fail_in;
   logic [cas_pkg::SlotBits-1:0] slot_ff;
   logic        hit_ff;
   logic [cas_pkg::WordBits-1:0] clr_ff;
   rec_type     rec_rd_ff;
   logic [63:0] bit_rd_ff;
   cas_pkg::rsp_type work_ff, work_in, rsp_ff, rsp_in;
   logic        rsp_valid_ff;

   // Lookup key and chunk index decode.
   logic [15:0] key;
   logic [15:0] idx;
   always_comb begin
      idx = req_ff.imm_word[15:0];
      if (req_ff.operation == cas_pkg::OP_CHUNK) begin
         key = req_ff.imm_word[31:16];
      end else begin
         key = req_ff.seq;
      end
   end

   // Tag match, lowest matching slot wins; also lowest free slot.
   logic [cas_pkg::SlotBits-1:0] match_slot, free_slot;
   logic match_hit, free_hit;
   always_comb begin
      match_slot = '0;
      match_hit  = 1'b0;
      free_slot  = '0;
      free_hit   = 1'b0;
      for (int i = cas_pkg::Slots - 1; i >= 0; i--) begin
         if (valid_ff[i] && tag_ff[i] == key) begin
            match_slot = cas_pkg::SlotBits'(i);
            match_hit  = 1'b1;
         end
         if (!valid_ff[i]) begin
            free_slot = cas_pkg::SlotBits'(i);
            free_hit  = 1'b1;
         end
      end
   end

   logic [4:0] active;
   always_comb begin
      active = '0;
      for (int i = 0; i < cas_pkg::Slots; i++) begin
         active = active + 5'(valid_ff[i]);
      end
   end

   // Execute stage decisions.
   logic        idx_ok;
   logic [5:0]  bitpos;
   logic        dup;
   logic [8:0]  rcv_inc;
   logic [15:0] add_seq;
   assign idx_ok  = (idx < 16'(rec_rd_ff.expected)) && (idx < 16'(cas_pkg::MaxChunks));
   assign bitpos  = idx[5:0];
   assign dup     = bit_rd_ff[bitpos];
   assign rcv_inc = rec_rd_ff.received + 9'd1;
   assign add_seq = (next_seq_ff == 16'd0) ? 16'd1 : next_seq_ff;

   logic        rec_we;
   rec_type     rec_wd;
   logic [cas_pkg::SlotBits-1:0] rec_wa;
   logic        bit_we;
   logic [63:0] bit_wd;
   logic [cas_pkg::BitmapAddrW-1:0] bit_wa, bit_ra;

   assign bit_ra = {match_slot, idx[7:6]};

   always_comb begin
      fsm_in      = fsm_ff;
      valid_in    = valid_ff;
      next_seq_in = next_seq_ff;
      added_in    = added_ff;
      done_in     = done_ff;
      fail_in     = fail_ff;
      work_in     = work_ff;
      rec_we      = 1'b0;
      rec_wd      = rec_rd_ff;
      rec_wa      = slot_ff;
      bit_we      = 1'b0;
      bit_wd      = bit_rd_ff | (64'd1 << bitpos);
      bit_wa      = {slot_ff, idx[7:6]};
      unique case (fsm_ff)
         S_IDLE: begin
            if (req_valid) begin
               fsm_in = S_READ;
            end
         end
         S_READ: begin
            fsm_in = S_EXEC;
         end
         S_EXEC: begin
            work_in = '0;
            work_in.status    = cas_pkg::ST_OK;
            work_in.seq_out   = key;
            work_in.state_out = rec_rd_ff.state;
            work_in.received  = rec_rd_ff.received;
            work_in.expected  = rec_rd_ff.expected;
            fsm_in = S_OUT;
            priority if (req_ff.operation == cas_pkg::OP_ADD) begin
               if (!free_hit) begin
                  work_in = '0;
                  work_in.status = cas_pkg::ST_FULL;
               end else begin
                  rec_we      = 1'b1;
                  rec_wa      = free_slot;
                  rec_wd      = '{seq: add_seq, state: cas_pkg::RQ_ASSIGNED,
                                  received: 9'd0, expected: 9'd0};
                  valid_in[free_slot] = 1'b1;
                  next_seq_in = add_seq + 16'd1;
                  added_in    = added_ff + 32'd1;
                  work_in.seq_out   = add_seq;
                  work_in.state_out = cas_pkg::RQ_ASSIGNED;
                  work_in.received  = 9'd0;
                  work_in.expected  = 9'd0;
               end
            end else if (req_ff.operation > cas_pkg::OP_QUERY) begin
               work_in = '0;
            end else if (!hit_ff) begin
               work_in.status    = cas_pkg::ST_NOT_FOUND;
               work_in.state_out = '0;
               work_in.received  = '0;
               work_in.expected  = '0;
            end else if (req_ff.operation == cas_pkg::OP_INIT) begin
               if (req_ff.chunk_total > 16'(cas_pkg::MaxChunks)) begin
                  work_in.status = cas_pkg::ST_TOO_MANY;
               end else begin
                  rec_we           = 1'b1;
                  rec_wd.received  = 9'd0;
                  rec_wd.expected  = req_ff.chunk_total[8:0];
                  work_in.received = 9'd0;
                  work_in.expected = req_ff.chunk_total[8:0];
                  fsm_in = S_CLEAR;
               end
            end else if (req_ff.operation == cas_pkg::OP_CHUNK) begin
               if (!idx_ok) begin
                  work_in.status = cas_pkg::ST_INVALID;
               end else if (dup) begin
                  work_in.status = cas_pkg::ST_DUPLICATE;
               end else begin
                  bit_we           = 1'b1;
                  rec_we           = 1'b1;
                  rec_wd.received  = rcv_inc;
                  work_in.received = rcv_inc;
                  work_in.complete = (rcv_inc == rec_rd_ff.expected);
               end
            end else if (req_ff.operation == cas_pkg::OP_STATE) begin
               rec_we            = 1'b1;
               rec_wd.state      = req_ff.target_state;
               work_in.state_out = req_ff.target_state;
               if (req_ff.target_state == cas_pkg::RQ_COMPLETED) begin
                  done_in = done_ff + 32'd1;
               end else if (req_ff.target_state == cas_pkg::RQ_FAILED) begin
                  fail_in = fail_ff + 32'd1;
               end
            end else if (req_ff.operation == cas_pkg::OP_REMOVE) begin
               valid_in[slot_ff] = 1'b0;
            end else begin
               work_in.status = cas_pkg::ST_OK;
            end
         end
         S_CLEAR: begin
            bit_we = 1'b1;
            bit_wd = '0;
            bit_wa = {slot_ff, clr_ff};
            if (clr_ff == cas_pkg::WordBits'(cas_pkg::WordsPerSlot - 1)) begin
               fsm_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               fsm_in = S_IDLE;
            end
         end
         default: begin
            fsm_in = S_IDLE;
         end
      endcase
   end

   // Response word: operation fields plus the counters after the operation.
   always_comb begin
      rsp_in                 = work_ff;
      rsp_in.total_added     = added_ff;
      rsp_in.completed_count = done_ff;
      rsp_in.failed_count    = fail_ff;
      rsp_in.active_count    = active;
   end

   // Memory ports: registered reads, single write port each.
   always_ff @(posedge clock) begin
      rec_rd_ff <= rec_mem[match_slot];
      bit_rd_ff <= bit_mem[bit_ra];
      if (rec_we) begin
         rec_mem[rec_wa] <= rec_wd;
         tag_ff[rec_wa]  <= rec_wd.seq;
      end
      if (bit_we) begin
         bit_mem[bit_wa] <= bit_wd;
      end
   end

   // Control and payload registers.
   always_ff @(posedge clock) begin
      if (fsm_ff == S_IDLE && req_valid) begin
         req_ff <= req_data;
      end
      if (fsm_ff == S_READ) begin
         slot_ff <= match_slot;
         hit_ff  <= match_hit;
      end
      if (fsm_ff == S_CLEAR) begin
         clr_ff <= clr_ff + 1'b1;
      end else begin
         clr_ff <= '0;
      end
      work_ff <= work_in;
      if (fsm_ff == S_OUT && fsm_in == S_IDLE) begin
         rsp_ff <= rsp_in;
      end
      if (reset) begin
         fsm_ff       <= S_IDLE;
         valid_ff     <= '0;
         next_seq_ff  <= 16'd1;
         added_ff     <= '0;
         done_ff      <= '0;
         fail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff      <= fsm_in;
         valid_ff    <= valid_in;
         next_seq_ff <= next_seq_in;
         added_ff    <= added_in;
         done_ff     <= done_in;
         fail_ff     <= fail_in;
         if (fsm_ff == S_OUT && fsm_in == S_IDLE) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Output register holds a word while the next request is already in work.
   assign req_stall = (fsm_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

   localparam logic [2:0] OpStats  = 3'd6;
   localparam logic [2:0] OpUnused = 3'd7;
   localparam int WatchdogLimit    = 2000;

   // Predicts each response word from a private copy of the tracker state.
   class tracker_scoreboard;
      bit            live [cas_pkg::Slots];
      logic [15:0]   tag [cas_pkg::Slots];
      logic [2:0]    rstate [cas_pkg::Slots];
      logic [8:0]    got [cas_pkg::Slots];
      logic [8:0]    want [cas_pkg::Slots];
      bit [cas_pkg::MaxChunks-1:0] seen [cas_pkg::Slots];
      logic [15:0]   next_tag;
      logic [31:0]   added, done_cnt, fail_cnt;
      cas_pkg::rsp_type pending [$];
      int            errors;

      function new();
         for (int i = 0; i < cas_pkg::Slots; i++) live[i] = 0;
         next_tag = 16'd1;
         added = 0;
         done_cnt = 0;
         fail_cnt = 0;
         errors = 0;
      endfunction

      function int lookup(logic [15:0] key);
         for (int i = 0; i < cas_pkg::Slots; i++)
            if (live[i] && tag[i] == key) return i;
         return -1;
      endfunction

      function int occupied();
         int n;
         n = 0;
         for (int i = 0; i < cas_pkg::Slots; i++) n += live[i];
         return n;
      endfunction

      function void show(ref cas_pkg::rsp_type r, input int s);
         r.state_out = rstate[s];
         r.received  = got[s];
         r.expected  = want[s];
      endfunction

      // Applies one accepted request word and queues the response it causes.
      function void note_request(cas_pkg::req_type q);
         cas_pkg::rsp_type r;
         int s;
         logic [15:0] key, idx, a;
         r = '0;
         r.status = cas_pkg::ST_OK;
         unique case (q.operation)
            cas_pkg::OP_ADD: begin
               s = -1;
               for (int i = cas_pkg::Slots - 1; i >= 0; i--) if (!live[i]) s = i;
               if (s < 0) begin
                  r.status = cas_pkg::ST_FULL;
               end else begin
                  a = (next_tag == 0) ? 16'd1 : next_tag;
                  next_tag = a + 16'd1;
                  live[s] = 1;
                  tag[s] = a;
                  rstate[s] = cas_pkg::RQ_ASSIGNED;
                  got[s] = 0;
                  want[s] = 0;
                  added++;
                  r.seq_out = a;
                  show(r, s);
               end
            end
            cas_pkg::OP_INIT: begin
               r.seq_out = q.seq;
               s = lookup(q.seq);
               if (s < 0) begin
                  r.status = cas_pkg::ST_NOT_FOUND;
               end else if (q.chunk_total > cas_pkg::MaxChunks) begin
                  r.status = cas_pkg::ST_TOO_MANY;
                  show(r, s);
               end else begin
                  want[s] = q.chunk_total[8:0];
                  got[s] = 0;
                  seen[s] = '0;
                  show(r, s);
               end
            end
            cas_pkg::OP_CHUNK: begin
               key = q.imm_word[31:16];
               idx = q.imm_word[15:0];
               r.seq_out = key;
               s = lookup(key);
               if (s < 0) begin
                  r.status = cas_pkg::ST_NOT_FOUND;
               end else begin
                  if (idx >= want[s] || idx >= cas_pkg::MaxChunks) begin
                     r.status = cas_pkg::ST_INVALID;
                  end else if (seen[s][idx[7:0]]) begin
                     r.status = cas_pkg::ST_DUPLICATE;
                  end else begin
                     seen[s][idx[7:0]] = 1;
                     got[s]++;
                     r.complete = (got[s] == want[s]);
                  end
                  show(r, s);
               end
            end
            cas_pkg::OP_STATE: begin
               r.seq_out = q.seq;
               s = lookup(q.seq);
               if (s < 0) begin
                  r.status = cas_pkg::ST_NOT_FOUND;
               end else begin
                  rstate[s] = q.target_state;
                  if (q.target_state == cas_pkg::RQ_COMPLETED) done_cnt++;
                  else if (q.target_state == cas_pkg::RQ_FAILED) fail_cnt++;
                  show(r, s);
               end
            end
            cas_pkg::OP_REMOVE, cas_pkg::OP_QUERY: begin
               r.seq_out = q.seq;
               s = lookup(q.seq);
               if (s < 0) begin
                  r.status = cas_pkg::ST_NOT_FOUND;
               end else begin
                  show(r, s);
                  if (q.operation == cas_pkg::OP_REMOVE) live[s] = 0;
               end
            end
            default: begin
            end
         endcase
         r.total_added = added;
         r.completed_count = done_cnt;
         r.failed_count = fail_cnt;
         r.active_count = 5'(occupied());
         pending = {pending, r};
      endfunction

      // Compares one response word against the oldest prediction.
      function void check_response(cas_pkg::rsp_type got_rsp);
         cas_pkg::rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response %h", $time, got_rsp);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got_rsp.status !== e.status)
            $display("%0t: status exp %0d got %0d", $time, e.status, got_rsp.status);
         if (got_rsp.seq_out !== e.seq_out)
            $display("%0t: seq_out exp %0d got %0d", $time, e.seq_out, got_rsp.seq_out);
         if (got_rsp.state_out !== e.state_out)
            $display("%0t: state_out exp %0d got %0d", $time, e.state_out,
                     got_rsp.state_out);
         if (got_rsp.received !== e.received)
            $display("%0t: received exp %0d got %0d", $time, e.received,
                     got_rsp.received);
         if (got_rsp.expected !== e.expected)
            $display("%0t: expected exp %0d got %0d", $time, e.expected,
                     got_rsp.expected);
         if (got_rsp.complete !== e.complete)
            $display("%0t: complete exp %0d got %0d", $time, e.complete,
                     got_rsp.complete);
         if (got_rsp.total_added !== e.total_added)
            $display("%0t: total_added exp %0d got %0d", $time, e.total_added,
                     got_rsp.total_added);
         if (got_rsp.completed_count !== e.completed_count)
            $display("%0t: completed_count exp %0d got %0d", $time,
                     e.completed_count, got_rsp.completed_count);
         if (got_rsp.failed_count !== e.failed_count)
            $display("%0t: failed_count exp %0d got %0d", $time, e.failed_count,
                     got_rsp.failed_count);
         if (got_rsp.active_count !== e.active_count)
            $display("%0t: active_count exp %0d got %0d", $time, e.active_count,
                     got_rsp.active_count);
         if (got_rsp !== e) errors++;
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   cas_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   cas_pkg::rsp_type rsp_data;

   tracker_scoreboard board = new();
   bit      quiet = 0;
   int      idle_cycles = 0;

   chunk_arrival_scoreboard uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // Response side: check accepted words, stall in random bursts.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) board.check_response(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 15);
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
            rsp_stall <= 0;
         end
      end
   end

   // Watchdog on cycles without any accepted word.
   always @(posedge clock) begin
      if (idle_cycles >= WatchdogLimit) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Sends one request word and waits for its acceptance, with random gaps.
   // Valid stays high after acceptance so the next word can follow directly.
   task automatic send_word(cas_pkg::req_type q);
      int n;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         n = $urandom_range(1, 15);
         req_valid <= 0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= q;
      do @(posedge clock); while (req_stall);
      board.note_request(q);
   endtask

   task automatic send_op(logic [2:0] op, logic [15:0] key, logic [31:0] imm,
                          logic [15:0] total, logic [2:0] ns);
      cas_pkg::req_type q;
      q.operation = op;
      q.seq = key;
      q.imm_word = imm;
      q.chunk_total = total;
      q.target_state = ns;
      send_word(q);
   endtask

   // Picks a sequence that is usually live in the predictor.
   function automatic logic [15:0] pick_key();
      int s;
      s = $urandom_range(0, cas_pkg::Slots - 1);
      if ($urandom_range(0, 9) != 0 && board.live[s]) return board.tag[s];
      if ($urandom_range(0, 1)) return board.next_tag - 16'd1;
      return 16'($urandom);
   endfunction

   task automatic random_word();
      logic [15:0] key, idx;
      int s, r;
      key = pick_key();
      s = board.lookup(key);
      idx = (s >= 0 && board.want[s] != 0) ? 16'($urandom_range(0, board.want[s] - 1))
                                            : 16'($urandom_range(0, 300));
      if ($urandom_range(0, 19) == 0) idx = 16'($urandom);
      r = $urandom_range(0, 99);
      if (r < 10)
         send_op(cas_pkg::OP_ADD, 16'($urandom), $urandom, 16'($urandom), 3'($urandom));
      else if (r < 20)
         send_op(cas_pkg::OP_INIT, key, $urandom,
                 ($urandom_range(0, 9) == 0) ? 16'($urandom)
                 : ($urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 256))
                                              : 16'($urandom_range(1, 12))),
                 3'($urandom));
      else if (r < 65)
         send_op(cas_pkg::OP_CHUNK, 16'($urandom), {key, idx}, 16'($urandom),
                 3'($urandom));
      else if (r < 75)
         send_op(cas_pkg::OP_STATE, key, $urandom, 16'($urandom), 3'($urandom));
      else if (r < 83)
         send_op(cas_pkg::OP_REMOVE, key, $urandom, 16'($urandom), 3'($urandom));
      else if (r < 93)
         send_op(cas_pkg::OP_QUERY, key, $urandom, 16'($urandom), 3'($urandom));
      else
         send_op($urandom_range(0, 1) ? OpStats : OpUnused, 16'($urandom), $urandom,
                 16'($urandom), 3'($urandom));
   endtask

   initial begin
      int k;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: unknown keys, full table, inits, chunk edges, state, removal.
      send_op(cas_pkg::OP_QUERY, 16'hFFFF, '1, '1, '1);
      send_op(cas_pkg::OP_CHUNK, 16'd0, 32'h0001_0000, 16'd0, 3'd0);
      for (int i = 0; i < cas_pkg::Slots + 1; i++) send_op(cas_pkg::OP_ADD, '0, '0, '0, '0);
      send_op(cas_pkg::OP_CHUNK, '0, 32'h0001_0000, '0, '0);
      send_op(cas_pkg::OP_INIT, 16'd1, '0, 16'd257, '0);
      send_op(cas_pkg::OP_INIT, 16'd1, '0, 16'd256, '0);
      send_op(cas_pkg::OP_CHUNK, '0, 32'h0001_00FF, '0, '0);
      send_op(cas_pkg::OP_CHUNK, '0, 32'h0001_00FF, '0, '0);
      send_op(cas_pkg::OP_CHUNK, '0, 32'h0001_0100, '0, '0);
      send_op(cas_pkg::OP_INIT, 16'd2, '0, 16'd1, '0);
      send_op(cas_pkg::OP_CHUNK, '0, 32'h0002_0000, '0, '0);
      send_op(cas_pkg::OP_CHUNK, '0, 32'h0002_0000, '0, '0);
      send_op(cas_pkg::OP_INIT, 16'd2, '0, 16'd1, '0);
      send_op(cas_pkg::OP_STATE, 16'd2, '0, '0, cas_pkg::RQ_COMPLETED);
      send_op(cas_pkg::OP_STATE, 16'd2, '0, '0, cas_pkg::RQ_COMPLETED);
      send_op(cas_pkg::OP_STATE, 16'd3, '0, '0, cas_pkg::RQ_FAILED);
      send_op(cas_pkg::OP_STATE, 16'd3, '0, '0, 3'd4);
      send_op(cas_pkg::OP_REMOVE, 16'd3, '0, '0, '0);
      send_op(cas_pkg::OP_REMOVE, 16'd3, '0, '0, '0);
      send_op(OpStats, '1, '1, '1, '1);
      send_op(OpUnused, '1, '1, '1, '1);

      // Pause until the block has drained.
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);

      // Random mix, with a quiet stretch at the end.
      for (k = 0; k < 1110; k++) begin
         if (k == 960) quiet = 1;
         random_word();
      end
      req_valid <= 0;

      k = 0;
      while (board.pending.size() != 0 && k < 5000) begin
         @(posedge clock);
         k++;
      end
      repeat (20) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
`default_nettype wire

// File: chunk_arrival_scoreboard.f
rtl/cas_pkg.sv
rtl/chunk_arrival_scoreboard.sv
verif/tb_top.sv
